### rtl/core/cctm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctm_pkg
// Shared types and constants for the cycle count to microseconds converter.
// ----------------------------------------------------------------------------
package cctm_pkg;

  localparam int CPM_W  = 20;
  localparam int FRAC_W = 31;
  localparam int TIME_W = 64;

  localparam logic [CPM_W-1:0] CPM_RESET = 20'd294912;
  localparam logic [9:0]       SCALE_K   = 10'd1000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_WHOLE,
    ST_SCALE,
    ST_DIV_FRAC,
    ST_MUL_A,
    ST_MUL_B,
    ST_ADD_A,
    ST_ADD_B,
    ST_NANO_A,
    ST_NANO_B,
    ST_OUT
  } state_t;

endpackage

### rtl/core/cycle_count_to_microseconds_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cycle_count_to_microseconds_top
// Turns samples of a free-running cycle counter into accumulated microseconds
// and nanoseconds, carrying the sub-microsecond remainder between samples.
// ----------------------------------------------------------------------------
// A word's result is loaded into the output register once the bit-serial
// divider has run once over the elapsed count and once over the 31-bit scaled
// leftover, followed by six passes through a shared 64-bit adder, and the
// output register is free. The block takes no new word before the last one
// has been loaded. in_ready is high only while idle; a finished word waits in
// the output register. The first sample after reset returns zero.
// cfg_wr_data of zero divides by one.
// ----------------------------------------------------------------------------
module cycle_count_to_microseconds_top
  import cctm_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COUNT_WIDTH-1:0] in_cycle_count,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [TIME_W-1:0]      out_elapsed_micros,
  output logic [TIME_W-1:0]      out_elapsed_nanos,
  input  logic                   cfg_wr_en,
  input  logic [CPM_W-1:0]       cfg_wr_data
);

  localparam int DW = (COUNT_WIDTH > FRAC_W) ? COUNT_WIDTH : FRAC_W;
  localparam int SW = $clog2(DW + 1);

  state_t state_r, state_nxt;

  logic [CPM_W-1:0]       cpm_r;
  logic [CPM_W-1:0]       divisor;
  logic [COUNT_WIDTH-1:0] last_count_r;
  logic                   started_r;
  logic [CPM_W-1:0]       carry_r;
  logic [TIME_W-1:0]      total_r;
  logic [TIME_W-1:0]      whole_r;
  logic [FRAC_W-1:0]      scaled_r;
  logic [FRAC_W-1:0]      frac_r;
  logic [TIME_W-1:0]      acc_r;
  logic                   out_valid_r;
  logic [TIME_W-1:0]      out_micros_r;
  logic [TIME_W-1:0]      out_nanos_r;

  logic                   accept;
  logic                   out_load;
  logic [COUNT_WIDTH-1:0] delta;
  logic                   div_start;
  logic [DW-1:0]          div_dividend;
  logic [SW-1:0]          div_steps;
  logic [DW-1:0]          div_quo;
  logic [CPM_W-1:0]       div_rem;
  logic                   div_done;
  logic [FRAC_W-1:0]      scaled_nxt;
  logic [TIME_W-1:0]      alu_a;
  logic [TIME_W-1:0]      alu_b;
  logic                   alu_sub;
  logic [TIME_W-1:0]      alu_sum;

  assign divisor  = (cpm_r == '0) ? CPM_W'(1) : cpm_r;
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign delta    = in_cycle_count - last_count_r;

  assign scaled_nxt = (FRAC_W'(div_rem) * FRAC_W'(SCALE_K)) + FRAC_W'(carry_r);
  assign alu_sum    = alu_a + (alu_b ^ {TIME_W{alu_sub}}) + TIME_W'(alu_sub);

  cctm_div #(
    .DW (DW),
    .SW (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .steps    (div_steps),
    .divisor  (divisor),
    .quo      (div_quo),
    .rem      (div_rem),
    .done     (div_done)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = started_r ? ST_DIV_WHOLE : ST_OUT;
        end
      end
      ST_DIV_WHOLE: begin
        if (div_done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE:    state_nxt = ST_DIV_FRAC;
      ST_DIV_FRAC: begin
        if (div_done) begin
          state_nxt = ST_MUL_A;
        end
      end
      ST_MUL_A:  state_nxt = ST_MUL_B;
      ST_MUL_B:  state_nxt = ST_ADD_A;
      ST_ADD_A:  state_nxt = ST_ADD_B;
      ST_ADD_B:  state_nxt = ST_NANO_A;
      ST_NANO_A: state_nxt = ST_NANO_B;
      ST_NANO_B: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // divider and adder controls; x*1000 = (x<<10) - (x<<3) - (x<<4)
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DW'(delta) << (DW - COUNT_WIDTH);
    div_steps    = SW'(COUNT_WIDTH);
    alu_a        = total_r;
    alu_b        = acc_r;
    alu_sub      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        div_start = accept && started_r;
      end
      ST_SCALE: begin
        div_start    = 1'b1;
        div_dividend = DW'(scaled_r) << (DW - FRAC_W);
        div_steps    = SW'(FRAC_W);
      end
      ST_MUL_A: begin
        alu_a   = whole_r << 10;
        alu_b   = whole_r << 3;
        alu_sub = 1'b1;
      end
      ST_MUL_B: begin
        alu_a   = acc_r;
        alu_b   = whole_r << 4;
        alu_sub = 1'b1;
      end
      ST_ADD_A: begin
        alu_a = total_r;
        alu_b = acc_r;
      end
      ST_ADD_B: begin
        alu_a = total_r;
        alu_b = TIME_W'(frac_r);
      end
      ST_NANO_A: begin
        alu_a   = total_r << 10;
        alu_b   = total_r << 3;
        alu_sub = 1'b1;
      end
      ST_NANO_B: begin
        alu_a   = acc_r;
        alu_b   = total_r << 4;
        alu_sub = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cpm_r        <= CPM_RESET;
      last_count_r <= '0;
      started_r    <= 1'b0;
      carry_r      <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cpm_r <= cfg_wr_data;
      end
      if (accept) begin
        last_count_r <= in_cycle_count;
        started_r    <= 1'b1;
      end
      if (state_r == ST_DIV_FRAC && div_done) begin
        carry_r <= div_rem;
      end
      if (state_r == ST_ADD_A || state_r == ST_ADD_B) begin
        total_r <= alu_sum;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !started_r) begin
      acc_r <= '0;
    end else if (state_r == ST_MUL_A || state_r == ST_MUL_B ||
                 state_r == ST_NANO_A || state_r == ST_NANO_B) begin
      acc_r <= alu_sum;
    end
    if (state_r == ST_DIV_WHOLE && div_done) begin
      whole_r  <= TIME_W'(div_quo[COUNT_WIDTH-1:0]);
      scaled_r <= scaled_nxt;
    end
    if (state_r == ST_DIV_FRAC && div_done) begin
      frac_r <= div_quo[FRAC_W-1:0];
    end
    if (out_load) begin
      out_micros_r <= total_r;
      out_nanos_r  <= acc_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_elapsed_micros = out_micros_r;
  assign out_elapsed_nanos  = out_nanos_r;

endmodule

### rtl/core/cctm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctm_div
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left-aligned and run for the given number of steps; quotient and remainder
// hold after done until the next start.
// ----------------------------------------------------------------------------
module cctm_div
  import cctm_pkg::*;
#(
  parameter int DW = 32,
  parameter int SW = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DW-1:0]    dividend,
  input  logic [SW-1:0]    steps,
  input  logic [CPM_W-1:0] divisor,
  output logic [DW-1:0]    quo,
  output logic [CPM_W-1:0] rem,
  output logic             done
);

  logic [DW-1:0]    quo_r, quo_nxt;
  logic [CPM_W-1:0] rem_r, rem_nxt;
  logic [SW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [CPM_W:0]   trial;
  logic [CPM_W:0]   diff;
  logic             ge;

  always_comb begin
    trial   = {rem_r, quo_r[DW-1]};
    diff    = trial - {1'b0, divisor};
    ge      = (trial >= {1'b0, divisor});
    rem_nxt = ge ? diff[CPM_W-1:0] : trial[CPM_W-1:0];
    quo_nxt = {quo_r[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - SW'(1);
        if (cnt_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cycle_count_to_microseconds_top. Counter samples go
// in over a valid/ready channel with random gaps and the output side stalls at
// random. Every accepted word updates an in-bench timekeeping model whose
// micros/nanos prediction is queued and compared against each result word.
// Directed cases cover the first sample, counter wrap and divisor extremes;
// random phases then sweep several divisor settings.
// ----------------------------------------------------------------------------
module tb;
  import cctm_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0] micros;
    logic [TIME_W-1:0] nanos;
  } time_word_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [31:0]       in_cycle_count;
  logic              out_valid;
  logic              out_ready;
  logic [TIME_W-1:0] out_elapsed_micros;
  logic [TIME_W-1:0] out_elapsed_nanos;
  logic              cfg_wr_en;
  logic [CPM_W-1:0]  cfg_wr_data;

  // timekeeping model state
  logic [CPM_W-1:0]  cpm_model   = CPM_RESET;
  logic [31:0]       last_sample = '0;
  logic [CPM_W-1:0]  carry_frac  = '0;
  logic [TIME_W-1:0] micros_acc  = '0;
  bit                sampled_yet = 1'b0;

  time_word_t  expected_times[$];
  logic [31:0] last_sent = '0;
  int          mismatch_count = 0;
  bit          quiet = 1'b0;

  cycle_count_to_microseconds_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cycle_count    (in_cycle_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_elapsed_micros(out_elapsed_micros),
    .out_elapsed_nanos (out_elapsed_nanos),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic time_word_t advance_time(input logic [31:0] now);
    logic [63:0] div, delta, whole, rest, scaled;
    logic [31:0] d32;
    time_word_t  r;
    div = (cpm_model == '0) ? 64'd1 : 64'(cpm_model);
    if (!sampled_yet) begin
      sampled_yet = 1'b1;
      last_sample = now;
      r.micros = '0;
      r.nanos  = '0;
      return r;
    end
    d32 = now - last_sample;
    delta = 64'(d32);
    last_sample = now;
    whole  = delta / div;
    rest   = delta % div;
    scaled = rest * SCALE_K + 64'(carry_frac);
    micros_acc = micros_acc + whole * SCALE_K + scaled / div;
    carry_frac = CPM_W'(scaled % div);
    r.micros = micros_acc;
    r.nanos  = micros_acc * SCALE_K;
    return r;
  endfunction

  function automatic int pick_gap();
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic note_error(input string what, input logic [63:0] exp_v,
                            input logic [63:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("ERROR %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
  endtask

  // sender: valid stays high across back-to-back words
  task automatic send_count(input logic [31:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cycle_count <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_times.push_back(advance_time(value));
    last_sent = value;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_times.size() != 0) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [CPM_W-1:0] value);
    settle();
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cpm_model = value;
  endtask

  // receiver with random stalls
  initial begin
    int gap;
    out_ready <= 1'b0;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    time_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_times.size() == 0) begin
        note_error("unexpected word micros", '0, out_elapsed_micros);
      end else begin
        exp_w = expected_times.pop_front();
        if (out_elapsed_micros !== exp_w.micros)
          note_error("elapsed_micros", exp_w.micros, out_elapsed_micros);
        if (out_elapsed_nanos !== exp_w.nanos)
          note_error("elapsed_nanos", exp_w.nanos, out_elapsed_nanos);
      end
    end
  end

  task automatic test_first_sample();
    quiet = 1'b0;
    send_count(32'hFFFF_FFFF);
    send_count(32'hFFFF_FFFF);
    send_count(32'h0000_0000);
    send_count(32'hFFFF_FFFF);
    send_count(last_sent + 32'(CPM_RESET));
    send_count(last_sent + 32'(CPM_RESET) / 2);
    send_count(last_sent + 32'(CPM_RESET) / 2 + 1);
  endtask

  task automatic test_divisor_extremes();
    write_divisor('0);
    send_count(last_sent + 32'd5);
    send_count(last_sent + 32'd1);
    write_divisor(20'd1);
    send_count(last_sent + 32'd7);
    write_divisor(20'hFFFFF);
    send_count(last_sent + 32'hFFFFE);
    send_count(last_sent + 32'hFFFFF);
    send_count(last_sent + 32'hFFFF_FFFF);
    send_count(last_sent + 32'd1);
    // big carry left over, then a tiny divisor
    write_divisor(20'd3);
    send_count(last_sent + 32'd1);
    send_count(last_sent + 32'd2);
    write_divisor(CPM_RESET);
  endtask

  task automatic test_random_samples();
    logic [CPM_W-1:0] div_set[8];
    logic [31:0]      nxt;
    int unsigned      span;
    div_set[0] = CPM_RESET;
    div_set[1] = 20'($urandom_range(1, 20'hFFFFF));
    div_set[2] = '0;
    div_set[3] = 20'hFFFFF;
    div_set[4] = 20'd1;
    div_set[5] = 20'd1000;
    div_set[6] = 20'($urandom_range(2, 16));
    div_set[7] = 20'($urandom_range(1, 20'hFFFFF));
    for (int ph = 0; ph < 8; ph++) begin
      write_divisor(div_set[ph]);
      quiet = (ph % 4 == 3);
      span = 32'(div_set[ph]) * 3 + 1;
      for (int i = 0; i < 200; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: nxt = last_sent + $urandom_range(0, span);
          5, 6:          nxt = last_sent + $urandom_range(0, 15);
          7, 8:          nxt = $urandom();
          default:       nxt = last_sent - $urandom_range(0, 15);
        endcase
        send_count(nxt);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cycle_count <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_sample();
    test_divisor_extremes();
    test_random_samples();
    settle();
    repeat (100) @(posedge clk);
    if (expected_times.size() != 0)
      note_error("words never returned", 64'(expected_times.size()), 64'd0);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
